[src/m4inv_pkg.sv]
// ----------------------------------------------------------------------------
// m4inv_pkg: shared constants and tables for the 4x4 adjugate inverse
// Default widths and the term table for a 3x3 minor expansion.
// ----------------------------------------------------------------------------
`default_nettype none

package m4inv_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // last load position of a matrix
    localparam logic [3:0] LAST_POS  = 4'd15;
    // six terms per 3x3 minor, numbered from zero
    localparam logic [2:0] TERM_LAST = 3'd5;

    // column (within the 3x3 minor) used by row f of term t
    function automatic logic [1:0] term_col(input logic [2:0] t, input logic [1:0] f);
        logic [5:0] perm;
        perm = 6'b10_01_00;
        case (t)
            3'd0:    perm = 6'b10_01_00;
            3'd1:    perm = 6'b01_10_00;
            3'd2:    perm = 6'b10_00_01;
            3'd3:    perm = 6'b00_10_01;
            3'd4:    perm = 6'b01_00_10;
            3'd5:    perm = 6'b00_01_10;
            default: perm = 6'b10_01_00;
        endcase
        case (f)
            2'd0:    term_col = perm[1:0];
            2'd1:    term_col = perm[3:2];
            default: term_col = perm[5:4];
        endcase
    endfunction

    // odd permutations enter the minor with a minus sign
    function automatic logic term_neg(input logic [2:0] t);
        term_neg = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

`default_nettype wire

[src/m4inv_mul.sv]
// ----------------------------------------------------------------------------
// m4inv_mul: bit-serial signed multiplier
// One multiplier bit per cycle, LSB first; the sign bit subtracts.
// ----------------------------------------------------------------------------
`default_nettype none

module m4inv_mul #(
    parameter int W  = m4inv_pkg::ELEM_WIDTH_DEF,
    parameter int XW = 4 * m4inv_pkg::ELEM_WIDTH_DEF + 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [XW-1:0] mcand,
    input  wire logic [W-1:0]  mplier,
    output logic               done,
    output logic [XW-1:0]      prod
);
    import m4inv_pkg::*;

    localparam int CW = $clog2(W);

    logic [XW-1:0] mc_reg;
    logic [W-1:0]  mp_reg;
    logic [XW-1:0] acc_reg, acc_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic          top_bit;

    assign top_bit = (cnt_reg == CW'(W - 1));

    always_comb
    begin
        acc_next = acc_reg;
        if (mp_reg[0])
        begin
            acc_next = top_bit ? (acc_reg - mc_reg) : (acc_reg + mc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (top_bit)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mc_reg  <= mcand;
            mp_reg  <= mplier;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            mc_reg  <= {mc_reg[XW-2:0], 1'b0};
            mp_reg  <= {1'b0, mp_reg[W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

[src/m4inv_div.sv]
// ----------------------------------------------------------------------------
// m4inv_div: bit-serial restoring divider
// Unsigned quotient, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module m4inv_div #(
    parameter int NW = 3 * m4inv_pkg::ELEM_WIDTH_DEF + 2 * m4inv_pkg::FRAC_BITS_DEF,
    parameter int DW = 4 * m4inv_pkg::ELEM_WIDTH_DEF + 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);
    import m4inv_pkg::*;

    localparam int CW = $clog2(NW);
    localparam int RW = DW + 1;

    logic [NW-1:0] n_reg, q_reg;
    logic [DW-1:0] d_reg;
    logic [RW-1:0] r_reg, rs, r_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg, ge;
    logic          last_bit;

    assign last_bit = (cnt_reg == CW'(NW - 1));

    always_comb
    begin
        rs     = {r_reg[RW-2:0], n_reg[NW-1]};
        ge     = (rs >= {1'b0, d_reg});
        r_next = ge ? (rs - {1'b0, d_reg}) : rs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (last_bit)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= num;
            d_reg <= den;
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= {q_reg[NW-2:0], ge};
            n_reg <= {n_reg[NW-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

[src/matrix4_inverse_adjugate_top.sv]
// Pacing: one matrix at a time; set by the bit-serial multiplier (W bits per
//   product, 6x2 products per minor) and the restoring divider (3W+2F bits each).
// Reset: asynchronous, active low; load position cleared, matrix store left as is.
// ----------------------------------------------------------------------------
// matrix4_inverse_adjugate_top: 4x4 fixed-point inverse by the adjugate
// Loads sixteen column-major words, builds the determinant and cofactors
// with a shared bit-serial multiplier, then divides each by the determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_inverse_adjugate_top #(
    parameter int ELEM_WIDTH = m4inv_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // element_value (bits above ELEM_WIDTH ignored)
    input  wire logic [((ELEM_WIDTH+7)/8)*8-1:0]    s_tdata,
    // restart
    input  wire logic [0:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // result_value, zero padded
    output logic [((ELEM_WIDTH+7)/8)*8-1:0]         m_tdata,
    // element_index[3:0], singular, saturated
    output logic [5:0]                              m_tuser,
    // last_of_matrix
    output logic                                    m_tlast
);
    import m4inv_pkg::*;

    localparam int W   = ELEM_WIDTH;
    localparam int TDW = ((ELEM_WIDTH + 7) / 8) * 8;
    localparam int XW  = 4 * W + 2;          // products and determinant
    localparam int MW  = 3 * W + 1;          // 3x3 minor
    localparam int NW  = 3 * W + 2 * FRAC_BITS; // scaled cofactor magnitude

    localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};
    localparam logic [NW-1:0] NEG_LIM = NW'(1) << (W - 1);

    typedef enum logic [3:0] {
        S_LOAD, S_TA, S_TB, S_M1, S_TC, S_M2, S_MDONE,
        S_DM, S_DCHK, S_DW, S_ECHO, S_OUT
    } state_t;

    state_t        state_reg;
    logic [3:0]    load_pos_reg, k_reg;
    logic [2:0]    term_reg;
    logic [1:0]    sc_reg;
    logic          phase_det_reg, sing_reg, sat_reg, neg_reg, valid_reg;
    logic [W-1:0]  a_reg, res_reg;
    logic [MW-1:0] minor_reg;
    logic [XW-1:0] det_reg;

    // element store: no reset, every read follows a full load
    logic [W-1:0]  store_reg [16];

    logic [3:0]    pos, rd_addr;
    logic [W-1:0]  rd_data, in_elem;
    logic          s_acc;

    // minor addressing
    logic [1:0]    skip_row, skip_col, lr, lc, ar, ac;
    logic [3:0]    term_addr;

    // shared units
    logic          mul_start, mul_done, div_start, div_done;
    logic [XW-1:0] mul_mcand, mul_prod;
    logic [W-1:0]  mul_mplier;
    logic [NW-1:0] div_num, div_quo;
    logic [XW-1:0] det_mag;

    logic [MW-1:0] cof, cof_mag, prod_m;
    logic          pos_big, neg_big;

    assign in_elem = s_tdata[W-1:0];
    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign pos      = s_tuser[0] ? 4'd0 : load_pos_reg;
    assign rd_data  = store_reg[rd_addr];

    // row f of the current term; skip the deleted row and column
    always_comb
    begin
        skip_row = phase_det_reg ? 2'd0 : k_reg[3:2];
        skip_col = phase_det_reg ? sc_reg : k_reg[1:0];
        case (state_reg)
            S_TA:    lr = 2'd0;
            S_TB:    lr = 2'd1;
            default: lr = 2'd2;
        endcase
        lc = term_col(term_reg, lr);
        ar = (lr >= skip_row) ? (lr + 2'd1) : lr;
        ac = (lc >= skip_col) ? (lc + 2'd1) : lc;
        term_addr = {ac, ar};
    end

    always_comb
    begin
        unique case (state_reg)
            S_TA, S_TB, S_TC: rd_addr = term_addr;
            S_MDONE:          rd_addr = {sc_reg, 2'b00};
            S_ECHO:           rd_addr = k_reg;
            default:          rd_addr = 4'd0;
        endcase
    end

    // cofactor sign is (-1)^(row+col)
    always_comb
    begin
        cof     = (k_reg[0] ^ k_reg[2]) ? (MW'(0) - minor_reg) : minor_reg;
        cof_mag = cof[MW-1] ? (MW'(0) - cof) : cof;
        det_mag = det_reg[XW-1] ? (XW'(0) - det_reg) : det_reg;
        div_num = NW'(cof_mag[MW-2:0]) << (2 * FRAC_BITS);
        prod_m  = mul_prod[MW-1:0];
        pos_big = (div_quo[NW-1:W-1] != '0);
        neg_big = (div_quo > NEG_LIM);
    end

    always_comb
    begin
        mul_start  = 1'b0;
        mul_mcand  = {{(XW-W){a_reg[W-1]}}, a_reg};
        mul_mplier = rd_data;
        div_start  = 1'b0;
        unique case (state_reg)
            S_TB:    mul_start = 1'b1;
            S_TC:
            begin
                mul_start = 1'b1;
                mul_mcand = mul_prod;
            end
            S_MDONE:
            begin
                mul_start = phase_det_reg;
                mul_mcand = {{(XW-MW){minor_reg[MW-1]}}, minor_reg};
                div_start = !phase_det_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            store_reg[pos] <= in_elem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_pos_reg  <= 4'd0;
            k_reg         <= 4'd0;
            term_reg      <= 3'd0;
            sc_reg        <= 2'd0;
            phase_det_reg <= 1'b0;
            sing_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            valid_reg     <= 1'b0;
            a_reg         <= '0;
            res_reg       <= '0;
            minor_reg     <= '0;
            det_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_acc)
                    begin
                        if (pos == LAST_POS)
                        begin
                            load_pos_reg  <= 4'd0;
                            phase_det_reg <= 1'b1;
                            sc_reg        <= 2'd0;
                            term_reg      <= 3'd0;
                            k_reg         <= 4'd0;
                            minor_reg     <= '0;
                            det_reg       <= '0;
                            state_reg     <= S_TA;
                        end
                        else
                        begin
                            load_pos_reg <= pos + 4'd1;
                        end
                    end
                end
                S_TA:
                begin
                    a_reg     <= rd_data;
                    state_reg <= S_TB;
                end
                S_TB:    state_reg <= S_M1;
                S_M1:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_TC;
                    end
                end
                S_TC:    state_reg <= S_M2;
                S_M2:
                begin
                    if (mul_done)
                    begin
                        minor_reg <= term_neg(term_reg) ? (minor_reg - prod_m)
                                                        : (minor_reg + prod_m);
                        if (term_reg == TERM_LAST)
                        begin
                            state_reg <= S_MDONE;
                        end
                        else
                        begin
                            term_reg  <= term_reg + 3'd1;
                            state_reg <= S_TA;
                        end
                    end
                end
                S_MDONE:
                begin
                    term_reg <= 3'd0;
                    if (phase_det_reg)
                    begin
                        state_reg <= S_DM;
                    end
                    else
                    begin
                        neg_reg   <= cof[MW-1] ^ det_reg[XW-1];
                        minor_reg <= '0;
                        state_reg <= S_DW;
                    end
                end
                S_DM:
                begin
                    if (mul_done)
                    begin
                        // cofactor expansion along the first row
                        det_reg   <= sc_reg[0] ? (det_reg - mul_prod) : (det_reg + mul_prod);
                        minor_reg <= '0;
                        if (sc_reg == 2'd3)
                        begin
                            state_reg <= S_DCHK;
                        end
                        else
                        begin
                            sc_reg    <= sc_reg + 2'd1;
                            state_reg <= S_TA;
                        end
                    end
                end
                S_DCHK:
                begin
                    phase_det_reg <= 1'b0;
                    k_reg         <= 4'd0;
                    sing_reg      <= (det_reg == '0);
                    state_reg     <= (det_reg == '0) ? S_ECHO : S_TA;
                end
                S_DW:
                begin
                    if (div_done)
                    begin
                        if (neg_reg)
                        begin
                            sat_reg <= neg_big;
                            res_reg <= neg_big ? MINV : (W'(0) - div_quo[W-1:0]);
                        end
                        else
                        begin
                            sat_reg <= pos_big;
                            res_reg <= pos_big ? MAXV : div_quo[W-1:0];
                        end
                        valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_ECHO:
                begin
                    // singular matrix: hand back the stored word
                    res_reg   <= rd_data;
                    sat_reg   <= 1'b0;
                    valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        valid_reg <= 1'b0;
                        if (k_reg == LAST_POS)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 4'd1;
                            state_reg <= sing_reg ? S_ECHO : S_TA;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    m4inv_mul #(
        .W  (W),
        .XW (XW)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    m4inv_div #(
        .NW (NW),
        .DW (XW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (det_mag),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDW'(res_reg);
    assign m_tuser  = {sat_reg, sing_reg, k_reg};
    assign m_tlast  = (k_reg == LAST_POS);

    // no word taken in while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while result pending");

    // echoed words are never flagged as clamped
    a_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[4]) |-> !m_tuser[5])
        else $error("singular word flagged saturated");

    // after the last result the block is ready to load again
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not back to loading after last result");

    // the divider is only started with a nonzero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (det_reg != '0))
        else $error("division started with zero determinant");

endmodule

`default_nettype wire

[test/m4inv_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// m4inv_checker: watcher and predictor for the 4x4 adjugate inverse
// Mirrors the load store, works out the sixteen inverse words of each matrix
// with wide signed arithmetic and compares every result word as it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module m4inv_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // element_value
    input  wire logic [0:0]  s_tuser,   // restart
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // result_value
    input  wire logic [5:0]  m_tuser,   // element_index[3:0], singular, saturated
    input  wire logic        m_tlast,   // last_of_matrix
    output int               fails,
    output int               pending,
    output int               words_checked,
    output int               singular_seen,
    output int               clamped_seen
);

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  index;
        logic        singular;
        logic        saturated;
        logic        last;
    } inv_word_t;

    logic [31:0] shadow_store [16];
    logic [3:0]  shadow_pos;
    inv_word_t   inverse_q [$];

    function automatic wide_t elem(input int r, input int c);
        logic [31:0] raw;
        raw  = shadow_store[c * 4 + r];
        elem = {{160{raw[31]}}, raw};
    endfunction

    // 3x3 determinant left after striking out one row and one column
    function automatic wide_t minor3(input int skip_r, input int skip_c);
        int    rs [3];
        int    cs [3];
        int    nr;
        int    nc;
        wide_t e [3][3];
        nr = 0;
        nc = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (i != skip_r) begin rs[nr] = i; nr++; end
            if (i != skip_c) begin cs[nc] = i; nc++; end
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = elem(rs[i], cs[j]);
        minor3 = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
               - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
               + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    endfunction

    task automatic predict_inverse();
        wide_t     det;
        wide_t     num;
        wide_t     quo;
        inv_word_t w;
        det = '0;
        for (int c = 0; c < 4; c++)
            if (c & 1) det = det - elem(0, c) * minor3(0, c);
            else       det = det + elem(0, c) * minor3(0, c);
        for (int k = 0; k < 16; k++)
        begin
            w.index     = k[3:0];
            w.last      = (k == 15);
            w.saturated = 1'b0;
            if (det == 0)
            begin
                // singular: stored matrix comes back as it was
                w.singular = 1'b1;
                w.value    = shadow_store[k];
            end
            else
            begin
                w.singular = 1'b0;
                // transposed cofactor, scaled by 2^32, truncating division
                num = minor3(k / 4, k % 4) <<< 32;
                if (((k / 4) + (k % 4)) & 1) num = -num;
                quo = num / det;
                if (quo > wide_t'(64'sd2147483647))
                begin
                    quo = wide_t'(64'sd2147483647);
                    w.saturated = 1'b1;
                end
                else if (quo < wide_t'(-64'sd2147483648))
                begin
                    quo = wide_t'(-64'sd2147483648);
                    w.saturated = 1'b1;
                end
                w.value = quo[31:0];
            end
            inverse_q.push_back(w);
        end
    endtask

    initial
    begin
        fails = 0;
        pending = 0;
        words_checked = 0;
        singular_seen = 0;
        clamped_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_pos <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                logic [3:0] p;
                p = s_tuser[0] ? 4'd0 : shadow_pos;
                shadow_store[p] = s_tdata;
                if (p == m4inv_pkg::LAST_POS)
                begin
                    shadow_pos <= '0;
                    predict_inverse();
                end
                else
                begin
                    shadow_pos <= p + 4'd1;
                end
            end
            if (m_tvalid && m_tready)
            begin
                inv_word_t got;
                inv_word_t want;
                got = {m_tdata, m_tuser[3:0], m_tuser[4], m_tuser[5], m_tlast};
                if (inverse_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result word %h", $time, got);
                end
                else
                begin
                    want = inverse_q.pop_front();
                    words_checked++;
                    if (want.singular && want.index == 0) singular_seen++;
                    if (want.saturated) clamped_seen++;
                    if (got !== want)
                    begin
                        fails++;
                        $display("%0t: mismatch exp val=%h idx=%0d sing=%b sat=%b last=%b",
                                 $time, want.value, want.index, want.singular,
                                 want.saturated, want.last);
                        $display("%0t:          got val=%h idx=%0d sing=%b sat=%b last=%b",
                                 $time, got.value, got.index, got.singular,
                                 got.saturated, got.last);
                    end
                end
            end
            pending = inverse_q.size();
        end
    end

endmodule

`default_nettype wire

[test/tb_matrix4_inverse_adjugate_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix4_inverse_adjugate_top: stimulus and verdict for the 4x4 inverse
// Streams directed and random matrices (well conditioned, singular, huge,
// tiny) with stray words between them, under varying back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix4_inverse_adjugate_top;

    localparam int WATCHDOG_LIMIT = 60000;   // cycles with no word moving

    typedef enum int { MX_FULL, MX_WELL, MX_SINGULAR, MX_HUGE, MX_TINY } mx_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;       // element_value
    logic [0:0]  s_tuser;       // restart
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // result_value
    logic [5:0]  m_tuser;       // element_index[3:0], singular, saturated
    logic        m_tlast;       // last_of_matrix

    int fails;
    int pending;
    int words_checked;
    int singular_seen;
    int clamped_seen;

    int words_sent;
    int matrices_sent;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    matrix4_inverse_adjugate_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    m4inv_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fails         (fails),
        .pending       (pending),
        .words_checked (words_checked),
        .singular_seen (singular_seen),
        .clamped_seen  (clamped_seen)
    );

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // receiver back-pressure, rate set by the current phase
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // watchdog: ends the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d words outstanding", pending);
            $display("tb: failure");
            $finish;
        end
    end

    // phases of idling and back-pressure, cycled by word count
    function automatic void pick_phase();
        case ((words_sent / 60) % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 69; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 36; stall_pct = 36; end
        endcase
    endfunction

    // one word on the slave side; ready is sampled mid-cycle, away from the edge
    task automatic send_word(input logic [31:0] value, input logic restart);
        logic ready_seen;
        pick_phase();
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(1));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= restart;
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        words_sent++;
    endtask

    function automatic logic [31:0] small_signed(input int mag);
        int v;
        v = $urandom_range(2 * mag) - mag;
        small_signed = v;
    endfunction

    task automatic send_matrix(input mx_kind_t kind, input logic force_restart);
        logic [31:0] m [16];
        int          dup;
        for (int k = 0; k < 16; k++)
        begin
            case (kind)
                MX_WELL:
                    if (k % 5 == 0)
                        m[k] = ($urandom_range(1) ? -1 : 1) * ($urandom_range(1, 4) << 16)
                             + small_signed(16'hffff);
                    else
                        m[k] = small_signed(1 << 14);
                MX_TINY: m[k] = small_signed(255);
                default: m[k] = $urandom;
            endcase
        end
        if (kind == MX_SINGULAR)
        begin
            // two equal columns, or a zero row
            dup = $urandom_range(3);
            if ($urandom_range(1))
                for (int r = 0; r < 4; r++) m[((dup + 1) % 4) * 4 + r] = m[dup * 4 + r];
            else
                for (int c = 0; c < 4; c++) m[c * 4 + dup] = '0;
        end
        for (int k = 0; k < 16; k++)
            send_word(m[k], (k == 0) && (force_restart || $urandom_range(3) != 0));
        matrices_sent++;
    endtask

    initial
    begin
        mx_kind_t kind;
        logic     misaligned;
        logic     drained;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        words_sent   = 0;
        matrices_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray partial load with extreme values, then the identity
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        for (int k = 0; k < 16; k++)
            send_word((k % 5 == 0) ? 32'h0001_0000 : 32'h0, k == 0);
        matrices_sent++;
        // early on: one singular, one tiny (overflow-prone) and one full matrix
        send_matrix(MX_SINGULAR, 1'b1);
        send_matrix(MX_TINY, 1'b0);
        send_matrix(MX_FULL, 1'b0);

        misaligned = 1'b0;
        drained    = 1'b0;
        while (words_sent < 480)
        begin
            // hold off once until the pipeline has drained completely
            if (!drained && words_sent >= 200)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
                drained = 1'b1;
            end
            if ($urandom_range(7) == 0)
            begin
                // noise: a few stray words, some restarting mid-matrix
                repeat ($urandom_range(1, 5)) send_word($urandom, 1'($urandom_range(1)));
                misaligned = 1'b1;
            end
            case ($urandom_range(9))
                0, 1, 2: kind = MX_WELL;
                3, 4:    kind = MX_FULL;
                5, 6:    kind = MX_SINGULAR;
                7:       kind = MX_HUGE;
                default: kind = MX_TINY;
            endcase
            send_matrix(kind, misaligned);
            misaligned = 1'b0;
        end

        @(posedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d words in, %0d matrices, %0d result words checked",
                 words_sent, matrices_sent, words_checked);
        $display("%0d singular matrices, %0d clamped words", singular_seen, clamped_seen);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
